FILE: rtl/rau_pkg.sv
package rau_pkg;

  // term widths of the input fractions
  localparam int TermW   = 16;
  localparam int DenW    = TermW - 1;
  // multiplier operands carry one extra bit so denominators stay positive
  localparam int OpW     = TermW + 1;
  localparam int ProdW   = 2 * OpW;
  // result field widths
  localparam int ResNumW = 32;
  localparam int ResDenW = 30;
  // magnitude width used by the gcd and divide engine
  localparam int MagW    = 32;
  localparam int ShW     = $clog2(MagW);
  localparam int CmdW    = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_CMP = 3'd4,
    CMD_RCP = 3'd5,
    CMD_RED = 3'd6
  } cmd_e;

  // request into the reduce engine
  typedef struct packed {
    logic            start;
    logic [MagW-1:0] num_mag;
    logic [MagW-1:0] den_mag;
  } red_req_t;

  // response from the reduce engine
  typedef struct packed {
    logic            done;
    logic [MagW-1:0] num_quo;
    logic [MagW-1:0] den_quo;
  } red_rsp_t;

endpackage

FILE: rtl/rau_mul.sv
module rau_mul (
  input  logic                                clk_i,
  input  logic signed [rau_pkg::OpW-1:0]      op_a_i,
  input  logic signed [rau_pkg::OpW-1:0]      op_b_i,
  output logic signed [rau_pkg::ProdW-1:0]    prod_o
);

  logic signed [rau_pkg::ProdW-1:0] prod_q;

  // one signed product per cycle, registered
  always_ff @(posedge clk_i) begin
    prod_q <= op_a_i * op_b_i;
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/rau_reduce.sv
module rau_reduce (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rau_pkg::red_req_t req_i,
  output rau_pkg::red_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_GCD  = 4'b0010,
    R_DIVN = 4'b0100,
    R_DIVD = 4'b1000
  } rstate_e;

  rstate_e                     state_q;
  logic [rau_pkg::MagW-1:0]    u_q, v_q, n0_q, d0_q, g_q;
  logic [rau_pkg::MagW-1:0]    dvd_q, rem_q, nquo_q;
  logic [rau_pkg::ShW-1:0]     k_q, cnt_q;
  logic                        done_q;

  // shared subtract unit: gcd compare/subtract or restoring divide step
  logic [rau_pkg::MagW:0]      sub_a, sub_b, sub_d;
  logic                        borrow;
  logic                        dividing;
  logic                        last_step;
  logic [rau_pkg::MagW-1:0]    rem_nxt, dvd_nxt;

  assign dividing  = (state_q == R_DIVN) || (state_q == R_DIVD);
  assign last_step = (cnt_q == rau_pkg::ShW'(rau_pkg::MagW - 1));

  always_comb begin
    if (dividing) begin
      sub_a = {rem_q, dvd_q[rau_pkg::MagW-1]};
      sub_b = {1'b0, g_q};
    end else begin
      sub_a = {1'b0, u_q};
      sub_b = {1'b0, v_q};
    end
  end

  assign sub_d   = sub_a - sub_b;
  assign borrow  = sub_d[rau_pkg::MagW];
  assign rem_nxt = borrow ? sub_a[rau_pkg::MagW-1:0] : sub_d[rau_pkg::MagW-1:0];
  assign dvd_nxt = {dvd_q[rau_pkg::MagW-2:0], ~borrow};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        R_IDLE: begin
          if (req_i.start) begin
            state_q <= R_GCD;
          end
        end
        R_GCD: begin
          if (u_q == '0) begin
            state_q <= R_DIVN;
          end
        end
        R_DIVN: begin
          if (last_step) begin
            state_q <= R_DIVD;
          end
        end
        R_DIVD: begin
          if (last_step) begin
            state_q <= R_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      R_IDLE: begin
        if (req_i.start) begin
          u_q  <= req_i.num_mag;
          v_q  <= req_i.den_mag;
          n0_q <= req_i.num_mag;
          d0_q <= req_i.den_mag;
          k_q  <= '0;
        end
      end
      R_GCD: begin
        // binary gcd, one shift, swap or subtract per cycle
        priority if (u_q == '0) begin
          g_q   <= v_q << k_q;
          dvd_q <= n0_q;
          rem_q <= '0;
          cnt_q <= '0;
        end else if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_q <= u_q >> 1;
        end else if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (borrow) begin
          u_q <= v_q;
          v_q <= u_q;
        end else begin
          u_q <= sub_d[rau_pkg::MagW-1:0];
        end
      end
      R_DIVN: begin
        if (last_step) begin
          nquo_q <= dvd_nxt;
          dvd_q  <= d0_q;
          rem_q  <= '0;
          cnt_q  <= '0;
        end else begin
          dvd_q <= dvd_nxt;
          rem_q <= rem_nxt;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      R_DIVD: begin
        dvd_q <= dvd_nxt;
        rem_q <= rem_nxt;
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.num_quo = nquo_q;
  assign rsp_o.den_quo = dvd_q;

endmodule

FILE: rtl/rational_arith_unit.sv
// a zero result or a zero denominator skips the reduce engine; every other result
//   passes through the gcd phase and both divides
// throughput: one transaction at a time; the next input is taken once the
//   previous result has left the core (it may still wait in the output register)
// the time is set by the binary gcd loop and two 32-step restoring divides
//   sharing one subtractor; rst_ni is asynchronous active low, clears control only
module rational_arith_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // a_num[15:0], a_den[30:16], b_num[46:31], b_den[61:47], zero pad [63:62]
  input  logic [63:0] s_axis_tdata,
  // cmd[2:0]
  input  logic [2:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // res_num[31:0], res_den[61:32], less[62], equal[63], greater[64], zero pad [71:65]
  output logic [71:0] m_axis_tdata,
  // status[0]
  output logic [0:0]  m_axis_tuser
);

  localparam int TermW   = rau_pkg::TermW;
  localparam int DenW    = rau_pkg::DenW;
  localparam int MagW    = rau_pkg::MagW;
  localparam int ResNumW = rau_pkg::ResNumW;
  localparam int ResDenW = rau_pkg::ResDenW;
  // input field offsets inside tdata
  localparam int AnLo    = 0;
  localparam int AdLo    = AnLo + TermW;
  localparam int BnLo    = AdLo + DenW;
  localparam int BdLo    = BnLo + TermW;
  localparam int OutPadW = 72 - (ResNumW + ResDenW + 3);

  // core sequencer, one-hot
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_FORM = 6'b000100,
    ST_FIX  = 6'b001000,
    ST_RED  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e                       state_q;
  logic [2:0]                   mcnt_q;
  rau_pkg::cmd_e                cmd_q;
  logic signed [TermW-1:0]      an_q, bn_q;
  logic [DenW-1:0]              ad_q, bd_q;

  // cross products and raw fraction
  logic signed [MagW-1:0]       lhs_q, rhs_q, nn_q, dd_q;
  logic signed [MagW-1:0]       num_q, den_q;
  logic                         less_q, equal_q, greater_q, neg_q;

  // core result
  logic [ResNumW-1:0]           rnum_q;
  logic [ResDenW-1:0]           rden_q;
  logic                         stat_q;

  // output register
  logic                         ov_q;
  logic [ResNumW-1:0]           onum_q;
  logic [ResDenW-1:0]           oden_q;
  logic                         olt_q, oeq_q, ogt_q, ost_q;

  logic                         in_fire, out_load;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // result leaves the core when the output register is empty or being drained
  assign out_load      = (state_q == ST_DONE) && (!ov_q || m_axis_tready);

  // ---------------------------------------------------------------------------
  // shared multiplier: an*bd, bn*ad, an*bn, ad*bd on successive cycles
  // ---------------------------------------------------------------------------
  logic signed [rau_pkg::OpW-1:0]   mop_a, mop_b;
  logic signed [rau_pkg::ProdW-1:0] prod;
  logic signed [MagW-1:0]           prod_w;

  always_comb begin
    unique case (mcnt_q)
      3'd0: begin
        mop_a = {an_q[TermW-1], an_q};
        mop_b = {2'b00, bd_q};
      end
      3'd1: begin
        mop_a = {bn_q[TermW-1], bn_q};
        mop_b = {2'b00, ad_q};
      end
      3'd2: begin
        mop_a = {an_q[TermW-1], an_q};
        mop_b = {bn_q[TermW-1], bn_q};
      end
      default: begin
        mop_a = {2'b00, ad_q};
        mop_b = {2'b00, bd_q};
      end
    endcase
  end

  rau_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mop_a),
    .op_b_i (mop_b),
    .prod_o (prod)
  );

  // every product fits in 32 signed bits
  assign prod_w = prod[MagW-1:0];

  // ---------------------------------------------------------------------------
  // raw fraction per command
  // ---------------------------------------------------------------------------
  logic signed [MagW-1:0] num_d, den_d;

  always_comb begin
    unique case (cmd_q)
      rau_pkg::CMD_ADD: begin
        num_d = lhs_q + rhs_q;
        den_d = dd_q;
      end
      rau_pkg::CMD_SUB: begin
        num_d = lhs_q - rhs_q;
        den_d = dd_q;
      end
      rau_pkg::CMD_MUL: begin
        num_d = nn_q;
        den_d = dd_q;
      end
      rau_pkg::CMD_DIV: begin
        num_d = lhs_q;
        den_d = rhs_q;
      end
      rau_pkg::CMD_RCP: begin
        num_d = {{(MagW-DenW){1'b0}}, ad_q};
        den_d = {{(MagW-TermW){an_q[TermW-1]}}, an_q};
      end
      rau_pkg::CMD_RED: begin
        num_d = {{(MagW-TermW){an_q[TermW-1]}}, an_q};
        den_d = {{(MagW-DenW){1'b0}}, ad_q};
      end
      // compare and the unused code give 0/1
      default: begin
        num_d = '0;
        den_d = MagW'(1);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // sign fix and reduce request: magnitudes do not depend on the sign fix
  // ---------------------------------------------------------------------------
  rau_pkg::red_req_t red_req;
  rau_pkg::red_rsp_t red_rsp;
  logic              den_zero, num_zero;

  assign den_zero        = (den_q == '0);
  assign num_zero        = (num_q == '0);
  assign red_req.start   = (state_q == ST_FIX) && !den_zero && !num_zero;
  assign red_req.num_mag = num_q[MagW-1] ? (MagW'(0) - num_q) : num_q;
  assign red_req.den_mag = den_q[MagW-1] ? (MagW'(0) - den_q) : den_q;

  rau_reduce u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (red_req),
    .rsp_o  (red_rsp)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mcnt_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          mcnt_q <= '0;
          if (in_fire) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          mcnt_q <= mcnt_q + 1'b1;
          if (mcnt_q == 3'd4) begin
            state_q <= ST_FORM;
          end
        end
        ST_FORM: state_q <= ST_FIX;
        ST_FIX: begin
          // zero denominator or zero numerator finish right away
          state_q <= red_req.start ? ST_RED : ST_DONE;
        end
        ST_RED: begin
          if (red_rsp.done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // core datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= rau_pkg::cmd_e'(s_axis_tuser);
      an_q  <= s_axis_tdata[AnLo +: TermW];
      ad_q  <= s_axis_tdata[AdLo +: DenW];
      bn_q  <= s_axis_tdata[BnLo +: TermW];
      bd_q  <= s_axis_tdata[BdLo +: DenW];
    end
    if (state_q == ST_MUL) begin
      unique case (mcnt_q)
        3'd1:    lhs_q <= prod_w;
        3'd2:    rhs_q <= prod_w;
        3'd3:    nn_q  <= prod_w;
        3'd4:    dd_q  <= prod_w;
        default: ;
      endcase
    end
    if (state_q == ST_FORM) begin
      num_q     <= num_d;
      den_q     <= den_d;
      // flags come from cross multiplication for every command
      less_q    <= (lhs_q < rhs_q);
      equal_q   <= (lhs_q == rhs_q);
      greater_q <= (lhs_q > rhs_q);
    end
    if (state_q == ST_FIX) begin
      neg_q  <= num_q[MagW-1] ^ den_q[MagW-1];
      stat_q <= den_zero;
      rnum_q <= '0;
      rden_q <= ResDenW'(1);
    end
    if ((state_q == ST_RED) && red_rsp.done) begin
      rnum_q <= neg_q ? ResNumW'(MagW'(0) - red_rsp.num_quo)
                      : ResNumW'(red_rsp.num_quo);
      rden_q <= red_rsp.den_quo[ResDenW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (m_axis_tready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      onum_q <= rnum_q;
      oden_q <= rden_q;
      olt_q  <= less_q;
      oeq_q  <= equal_q;
      ogt_q  <= greater_q;
      ost_q  <= stat_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, ogt_q, oeq_q, olt_q, oden_q, onum_q};
  assign m_axis_tuser  = ost_q;

`ifndef ASSERT_OFF
  // an error result is always 0/1
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ost_q) |-> (onum_q == '0) && (oden_q == ResDenW'(1)))
    else $error("error transaction without 0/1 result");

  // delivered denominator never zero
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (oden_q != '0))
    else $error("zero result denominator");

  // exactly one comparison flag
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> $onehot({olt_q, oeq_q, ogt_q}))
    else $error("comparison flags not one-hot");

  // reduce engine answers only while the sequencer waits for it
  a_red_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_rsp.done |-> (state_q == ST_RED))
    else $error("reduce done outside wait state");

  // a reduce request leads into the wait state
  a_red_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_req.start |=> (state_q == ST_RED))
    else $error("reduce start not followed by wait state");
`endif

endmodule

FILE: tb/rational_arith_unit_tb.sv
`timescale 1ns / 100ps

module rational_arith_unit_tb;

  // command value outside the enum, the block treats it as a compare
  localparam logic [rau_pkg::CmdW-1:0] CmdUnused = 3'd7;
  // cycles the sink holds off during the backpressure test
  localparam int StallCycles = 700;
  // cycles to wait after the last result, covers the slowest gcd pass
  localparam int TailCycles  = 250;

  // one predicted result transaction
  typedef struct packed {
    logic [rau_pkg::ResNumW-1:0] num;
    logic [rau_pkg::ResDenW-1:0] den;
    logic                        less;
    logic                        equal;
    logic                        greater;
    logic                        status;
  } frac_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // a_num[15:0], a_den[30:16], b_num[46:31], b_den[61:47], zero pad [63:62]
  logic [63:0] s_axis_tdata;
  // cmd[2:0]
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // res_num[31:0], res_den[61:32], less[62], equal[63], greater[64], zero pad [71:65]
  logic [71:0] m_axis_tdata;
  // status[0]
  logic [0:0]  m_axis_tuser;

  // results still owed by the block, oldest first
  frac_result_t expected_results[$];
  int           mismatches;
  int           results_seen;
  // both sides stop idling while this is set
  bit           steady;
  // bumped by a test to make the sink hold off
  int           stall_reqs;

  rational_arith_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // euclid on non-negative magnitudes
  function automatic longint gcd_mag(longint x, longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_result_t predict_result(logic [rau_pkg::CmdW-1:0] cmd,
                                                  logic [rau_pkg::TermW-1:0] an,
                                                  logic [rau_pkg::DenW-1:0] ad,
                                                  logic [rau_pkg::TermW-1:0] bn,
                                                  logic [rau_pkg::DenW-1:0] bd);
    frac_result_t r;
    longint       a_n;
    longint       a_d;
    longint       b_n;
    longint       b_d;
    longint       lhs;
    longint       rhs;
    longint       n;
    longint       d;
    longint       g;
    a_n = $signed(an);
    a_d = ad;
    b_n = $signed(bn);
    b_d = bd;
    // flags always come from the cross products
    lhs = a_n * b_d;
    rhs = b_n * a_d;
    case (cmd)
      rau_pkg::CMD_ADD: begin
        n = a_n * b_d + b_n * a_d;
        d = a_d * b_d;
      end
      rau_pkg::CMD_SUB: begin
        n = a_n * b_d - b_n * a_d;
        d = a_d * b_d;
      end
      rau_pkg::CMD_MUL: begin
        n = a_n * b_n;
        d = a_d * b_d;
      end
      rau_pkg::CMD_DIV: begin
        n = a_n * b_d;
        d = a_d * b_n;
      end
      rau_pkg::CMD_RCP: begin
        n = a_d;
        d = a_n;
      end
      rau_pkg::CMD_RED: begin
        n = a_n;
        d = a_d;
      end
      default: begin
        // compare and the unused code give 0/1
        n = 0;
        d = 1;
      end
    endcase
    r.status = 1'b0;
    if (d == 0) begin
      // zero denominator: error status, result forced to 0/1
      r.status = 1'b1;
      n = 0;
      d = 1;
    end else begin
      // sign moves to the numerator
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      if (n == 0) begin
        d = 1;
      end else begin
        g = gcd_mag((n < 0) ? -n : n, d);
        n = n / g;
        d = d / g;
      end
    end
    r.num     = n[rau_pkg::ResNumW-1:0];
    r.den     = d[rau_pkg::ResDenW-1:0];
    r.less    = lhs < rhs;
    r.equal   = lhs == rhs;
    r.greater = lhs > rhs;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t ns: result %0d field %s got %0d expected %0d",
             $realtime, results_seen, field, got, want);
    mismatches++;
  endtask

  // compare every result transaction with the oldest prediction
  always @(posedge clk_i) begin
    frac_result_t want;
    frac_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.num     = m_axis_tdata[31:0];
      got.den     = m_axis_tdata[61:32];
      got.less    = m_axis_tdata[62];
      got.equal   = m_axis_tdata[63];
      got.greater = m_axis_tdata[64];
      got.status  = m_axis_tuser[0];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected", 0, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.num != want.num)
          report_mismatch("res_num", $signed(got.num), $signed(want.num));
        if (got.den != want.den) report_mismatch("res_den", got.den, want.den);
        if (got.less != want.less) report_mismatch("less", got.less, want.less);
        if (got.equal != want.equal) report_mismatch("equal", got.equal, want.equal);
        if (got.greater != want.greater)
          report_mismatch("greater", got.greater, want.greater);
        if (got.status != want.status)
          report_mismatch("status", got.status, want.status);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: random tready, plus a counted hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int hold_left;
    int seen_reqs;
    hold_left = 0;
    seen_reqs = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_reqs != seen_reqs) begin
        seen_reqs = stall_reqs;
        hold_left = StallCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 37);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one transaction, returns at the accepting rising edge
  // tvalid is left high so back-to-back transactions never toggle it
  task automatic send_item(logic [rau_pkg::CmdW-1:0] cmd, logic [rau_pkg::TermW-1:0] an,
                           logic [rau_pkg::DenW-1:0] ad, logic [rau_pkg::TermW-1:0] bn,
                           logic [rau_pkg::DenW-1:0] bd);
    int gap;
    @(negedge clk_i);
    if (!steady) begin
      // now and then a long gap so it lands on any phase of the gcd work
      gap = ($urandom_range(19) == 0) ? $urandom_range(150) : 0;
      while (gap > 0 || $urandom_range(99) < 37) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
        if (gap > 0) gap--;
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, bd, bn, ad, an};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(predict_result(cmd, an, ad, bn, bd));
  endtask

  // drop tvalid and wait until every prediction has been matched
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // numerator biased toward extremes, zero and small values
  function automatic logic [rau_pkg::TermW-1:0] pick_num();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4, 5: return rau_pkg::TermW'($urandom_range(24)) - 16'd12;
      default: return rau_pkg::TermW'($urandom());
    endcase
  endfunction

  // denominator mostly positive, zero only rarely
  function automatic logic [rau_pkg::DenW-1:0] pick_den();
    case ($urandom_range(31))
      0: return '0;
      1, 2: return 15'd1;
      3, 4: return 15'h7fff;
      5, 6, 7, 8, 9, 10: return rau_pkg::DenW'($urandom_range(1, 24));
      default: return rau_pkg::DenW'($urandom_range(1, 32767));
    endcase
  endfunction

  // all command codes, the unused one now and then
  function automatic logic [rau_pkg::CmdW-1:0] pick_cmd();
    if ($urandom_range(29) == 0) return CmdUnused;
    return rau_pkg::CmdW'($urandom_range(6));
  endfunction

  task automatic send_random();
    send_item(pick_cmd(), pick_num(), pick_den(), pick_num(), pick_den());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, every command and each special case
  task automatic test_directed();
    send_item(rau_pkg::CMD_ADD, 16'd1, 15'd2, 16'd1, 15'd3);           // 1/2 + 1/3
    send_item(rau_pkg::CMD_ADD, 16'h7fff, 15'h7fff, 16'h7fff, 15'h7fff);
    send_item(rau_pkg::CMD_SUB, 16'd1, 15'd2, 16'd2, 15'd4);           // zero result
    send_item(rau_pkg::CMD_SUB, 16'h8000, 15'h7fff, 16'h7fff, 15'h7fff);
    send_item(rau_pkg::CMD_MUL, 16'h8000, 15'd1, 16'h8000, 15'd1);
    send_item(rau_pkg::CMD_MUL, 16'hfffd, 15'd4, 16'd6, 15'd9);
    send_item(rau_pkg::CMD_DIV, 16'd3, 15'd4, 16'hfffe, 15'd5);        // negative divisor
    send_item(rau_pkg::CMD_DIV, 16'd5, 15'd7, 16'd0, 15'd3);           // divide by zero
    send_item(rau_pkg::CMD_DIV, 16'h8000, 15'h7fff, 16'h8000, 15'd1);
    send_item(rau_pkg::CMD_CMP, 16'd1, 15'd2, 16'd2, 15'd4);           // equal
    send_item(rau_pkg::CMD_CMP, 16'h8000, 15'd1, 16'h7fff, 15'd1);     // less
    send_item(rau_pkg::CMD_CMP, 16'h7fff, 15'd1, 16'h8000, 15'h7fff);  // greater
    send_item(rau_pkg::CMD_RCP, 16'hfffa, 15'd4, 16'd0, 15'd1);        // negative a
    send_item(rau_pkg::CMD_RCP, 16'd0, 15'd9, 16'd1, 15'd1);           // reciprocal of zero
    send_item(rau_pkg::CMD_RCP, 16'h8000, 15'h7fff, 16'h7fff, 15'd1);
    send_item(rau_pkg::CMD_RED, 16'd6, 15'd4, 16'd0, 15'd1);
    send_item(rau_pkg::CMD_RED, 16'h8000, 15'h4000, 16'd0, 15'd1);
    send_item(rau_pkg::CMD_RED, 16'd0, 15'h7fff, 16'd0, 15'd0);        // zero numerator
    send_item(rau_pkg::CMD_ADD, 16'd3, 15'd0, 16'd1, 15'd2);           // zero input den
    send_item(rau_pkg::CMD_MUL, 16'd3, 15'd5, 16'd1, 15'd0);
    send_item(rau_pkg::CMD_CMP, 16'd3, 15'd0, 16'd1, 15'd0);           // compare, zero dens
    send_item(CmdUnused, 16'd1, 15'd3, 16'd1, 15'd2);                  // unused code
    send_item(CmdUnused, 16'h7fff, 15'h7fff, 16'h7fff, 15'h7fff);
    send_item(rau_pkg::CMD_RED, 16'hffff, 15'h5555, 16'hffff, 15'h2aaa);
    drain_results();
  endtask

  // random traffic with random idling on both sides
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) send_random();
    drain_results();
  endtask

  // no idling anywhere for a long stretch
  task automatic test_steady(int count);
    steady = 1'b1;
    for (int i = 0; i < count; i++) send_random();
    drain_results();
    steady = 1'b0;
  endtask

  // sink holds off while the source keeps offering, so the core and the
  // output register fill up and tready drops
  task automatic test_backpressure(int count);
    steady = 1'b1;
    send_random();
    stall_reqs++;
    for (int i = 1; i < count; i++) send_random();
    drain_results();
    steady = 1'b0;
  endtask

  // source waits for all results, then resumes
  task automatic test_pause_resume(int count);
    for (int i = 0; i < count; i++) begin
      send_random();
      if (i % 10 == 9) drain_results();
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    mismatches    = 0;
    results_seen  = 0;
    steady        = 1'b0;
    stall_reqs    = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(400);
    test_backpressure(8);
    test_steady(150);
    test_pause_resume(60);
    test_backpressure(6);
    test_random(300);

    // let any stray result show up before the verdict
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: rational_arith_unit.f
rtl/rau_pkg.sv
rtl/rau_mul.sv
rtl/rau_reduce.sv
rtl/rational_arith_unit.sv
tb/rational_arith_unit_tb.sv
